### design/sfr_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and the crc-16 step for the stuffed frame receiver
package sfr_pkg;

  // framing characters
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_DLE = 8'h10;

  // checksum modes
  localparam logic [1:0] CSUM_NONE  = 2'd0;
  localparam logic [1:0] CSUM_CRC16 = 2'd1;
  localparam logic [1:0] CSUM_SUM8  = 2'd2;

  // register index of checksum_mode
  localparam logic REG_CHECKSUM_MODE = 1'b0;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // commands
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_ABORT = 1'b1;

  typedef enum logic [1:0] {
    PM_IDLE,
    PM_FRAME,
    PM_ESCAPED,
    PM_SKIP
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_GOOD     = 3'd0,
    ST_BADSUM   = 3'd1,
    ST_SHORT    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_RESTART  = 3'd4,
    ST_ABORT    = 3'd5
  } frame_status_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic       is_frame_end;
    logic [7:0] payload_byte;
    logic [2:0] frame_status;
    logic [8:0] payload_length;
  } out_beat_t;

  // crc-16/ccitt-false, msb first, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (x[15]) begin
        x = {x[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[14:0], 1'b0};
      end
    end
    return x;
  endfunction

endpackage

### design/stuffed_frame_receiver_core.sv
`timescale 1ns / 1ps
// a result is in the output register in the cycle after its input beat is taken
// throughput: one input beat per cycle while in_ready is high; the parser state updates in a single pass
// in_ready is high whenever the output register is empty or being drained
// a beat that causes no result leaves the output register untouched
// synchronous reset: parser idle, checksum mode none, crc 0xffff, output empty
module stuffed_frame_receiver_core import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       checksum_mode;
  logic [1:0] mode;
  logic       fire;
  logic       res_valid;
  out_beat_t  res;
  logic       reg_wr;

  assign checksum_mode = (paddr[2] == REG_CHECKSUM_MODE);
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && checksum_mode;
  assign prdata = checksum_mode ? {30'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= CSUM_NONE;
    end else if (reg_wr) begin
      mode <= pwdata[1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  sfr_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_deframer (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .beat      (in_data),
    .mode      (mode),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_data <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat lost before it was taken");

  a_load_on_result: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> out_valid)
    else $error("result not loaded into the output register");

  a_idle_clears: assert property (@(posedge clk) disable iff (rst)
    out_ready && !(fire && res_valid) |=> !out_valid)
    else $error("output register kept a drained beat");

endmodule

### design/sfr_deframer.sv
`timescale 1ns / 1ps
// deframing state machine: unstuffing, holdback, checksum and frame-end status
module sfr_deframer import sfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_beat_t  beat,
  input  logic [1:0] mode,
  output logic      res_valid,
  output out_beat_t res
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

  parse_mode_t   pm, pm_next;
  logic [CW-1:0] count, count_next;
  logic [7:0]    hb0, hb0_next, hb1, hb1_next;
  logic [1:0]    fill, fill_next;
  logic [15:0]   crc, crc_next;
  logic [7:0]    sum, sum_next;
  logic          ovf, ovf_next;

  logic [1:0]    hlen;
  logic          take;
  logic [7:0]    take_byte;
  logic          is_data;
  logic [31:0]   count_wide;
  logic [7:0]    sum_want;
  logic [7:0]    sum_got;
  frame_status_t end_status;

  always_comb begin
    case (mode)
      CSUM_CRC16: hlen = 2'd2;
      CSUM_SUM8:  hlen = 2'd1;
      default:    hlen = 2'd0;
    endcase
  end

  assign count_wide = 32'(count);
  assign sum_want   = 8'(8'd0 - sum);
  assign sum_got    = (fill == 2'd2) ? hb1 : hb0;

  // status at etx, highest priority first
  always_comb begin
    if (ovf) begin
      end_status = ST_OVERFLOW;
    end else if (hlen != 2'd0 && (fill < hlen || count == '0)) begin
      end_status = ST_SHORT;
    end else if (hlen == 2'd2 && {hb0, hb1} != crc) begin
      end_status = ST_BADSUM;
    end else if (hlen == 2'd1 && sum_got != sum_want) begin
      end_status = ST_BADSUM;
    end else begin
      end_status = ST_GOOD;
    end
  end

  always_comb begin
    pm_next    = pm;
    count_next = count;
    hb0_next   = hb0;
    hb1_next   = hb1;
    fill_next  = fill;
    crc_next   = crc;
    sum_next   = sum;
    ovf_next   = ovf;
    res_valid  = 1'b0;
    res        = '0;
    is_data    = 1'b0;
    take       = 1'b0;
    take_byte  = beat.rx_byte;

    if (beat.command == CMD_ABORT) begin
      pm_next = PM_IDLE;
      if (pm == PM_FRAME || pm == PM_ESCAPED) begin
        res_valid          = 1'b1;
        res.is_frame_end   = 1'b1;
        res.frame_status   = ST_ABORT;
        res.payload_length = count_wide[8:0];
      end
    end else begin
      case (pm)
        PM_IDLE: begin
          if (beat.rx_byte == CH_DLE) begin
            pm_next = PM_SKIP;
          end else if (beat.rx_byte == CH_STX) begin
            pm_next    = PM_FRAME;
            count_next = '0;
            hb0_next   = '0;
            hb1_next   = '0;
            fill_next  = '0;
            crc_next   = CRC_INIT;
            sum_next   = '0;
            ovf_next   = 1'b0;
          end
        end
        PM_SKIP: begin
          pm_next = PM_IDLE;
        end
        PM_ESCAPED: begin
          pm_next = PM_FRAME;
          is_data = 1'b1;
        end
        PM_FRAME: begin
          if (beat.rx_byte == CH_DLE) begin
            pm_next = PM_ESCAPED;
          end else if (beat.rx_byte == CH_STX) begin
            res_valid          = 1'b1;
            res.is_frame_end   = 1'b1;
            res.frame_status   = ST_RESTART;
            res.payload_length = count_wide[8:0];
            count_next = '0;
            hb0_next   = '0;
            hb1_next   = '0;
            fill_next  = '0;
            crc_next   = CRC_INIT;
            sum_next   = '0;
            ovf_next   = 1'b0;
          end else if (beat.rx_byte == CH_ETX) begin
            pm_next            = PM_IDLE;
            res_valid          = 1'b1;
            res.is_frame_end   = 1'b1;
            res.frame_status   = end_status;
            res.payload_length = count_wide[8:0];
          end else begin
            is_data = 1'b1;
          end
        end
        default: begin
          pm_next = PM_IDLE;
        end
      endcase
    end

    // holdback: a byte enters, the oldest leaves once the trailer is covered
    if (is_data) begin
      if (fill < hlen) begin
        if (fill[0]) begin
          hb1_next = beat.rx_byte;
        end else begin
          hb0_next = beat.rx_byte;
        end
        fill_next = fill + 2'd1;
      end else if (fill == 2'd0) begin
        take = 1'b1;
      end else begin
        take      = 1'b1;
        take_byte = hb0;
        if (fill >= 2'd2) begin
          hb0_next = hb1;
          hb1_next = beat.rx_byte;
        end else begin
          hb0_next = beat.rx_byte;
        end
      end
    end

    if (take) begin
      if (count >= CNT_MAX) begin
        ovf_next = 1'b1;
      end else begin
        count_next       = count + CW'(1);
        crc_next         = crc16_step(crc, take_byte);
        sum_next         = sum + take_byte;
        res_valid        = 1'b1;
        res.payload_byte = take_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pm    <= PM_IDLE;
      count <= '0;
      hb0   <= '0;
      hb1   <= '0;
      fill  <= '0;
      crc   <= CRC_INIT;
      sum   <= '0;
      ovf   <= 1'b0;
    end else if (fire) begin
      pm    <= pm_next;
      count <= count_next;
      hb0   <= hb0_next;
      hb1   <= hb1_next;
      fill  <= fill_next;
      crc   <= crc_next;
      sum   <= sum_next;
      ovf   <= ovf_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_MAX)
    else $error("payload count past limit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("holdback fill past two");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && !res.is_frame_end |-> (pm == PM_FRAME || pm == PM_ESCAPED))
    else $error("payload beat outside a frame");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.is_frame_end && res.frame_status != ST_RESTART
    |=> pm == PM_IDLE)
    else $error("frame end did not return to idle");

  a_restart_in_frame: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.frame_status == ST_RESTART |=> pm == PM_FRAME && count == '0)
    else $error("restart did not open an empty frame");

endmodule

### test/stuffed_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// testbench for stuffed_frame_receiver_core: directed table, then random framed traffic
module stuffed_frame_receiver_core_tb;
  import sfr_pkg::*;

  localparam int PAYLOAD_CAP = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_PAD = 3;
  localparam logic [2:0] MODE_ADDR = 3'(4 * REG_CHECKSUM_MODE);

  typedef enum {CHK_PREDICT, CHK_NONE, CHK_BEAT} check_t;

  typedef struct {
    int        new_mode;
    in_beat_t  beat;
    check_t    kind;
    out_beat_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stuffed_frame_receiver_core #(.MAX_PAYLOAD(PAYLOAD_CAP)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // deframer state as the testbench sees it
  logic [1:0]  mode_reg;
  parse_mode_t rx_state;
  logic [8:0]  dlv_count;
  logic [7:0]  held [2];
  logic [1:0]  held_fill;
  logic [15:0] crc_acc;
  logic [7:0]  sum_acc;
  bit          ovf_seen;

  out_beat_t deframed_due[$];
  dir_row_t  dir_rows[$];
  int        err_count;
  int        beats_sent;
  int        cycle_count;
  bit        calm_tail;
  bit        hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_mismatch(input string what);
    err_count++;
    if (err_count <= 30) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  function automatic out_beat_t pay(input logic [7:0] v);
    out_beat_t r;
    r = '0;
    r.payload_byte = v;
    return r;
  endfunction

  function automatic out_beat_t fin(input frame_status_t st, input int len);
    out_beat_t r;
    r = '0;
    r.is_frame_end = 1'b1;
    r.frame_status = st;
    r.payload_length = 9'(len);
    return r;
  endfunction

  function automatic dir_row_t mk_row(input int new_mode, input logic cmd,
                                      input logic [7:0] v, input check_t kind,
                                      input out_beat_t want);
    dir_row_t d;
    d.new_mode = new_mode;
    d.beat.command = cmd;
    d.beat.rx_byte = v;
    d.kind = kind;
    d.want = want;
    return d;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] v);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ v[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic int trailer_bytes();
    case (mode_reg)
      CSUM_CRC16: return 2;
      CSUM_SUM8: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic void open_frame();
    dlv_count = '0;
    held[0] = '0;
    held[1] = '0;
    held_fill = '0;
    crc_acc = CRC_INIT;
    sum_acc = '0;
    ovf_seen = 1'b0;
  endfunction

  // a byte leaving the holdback: counted and summed, or dropped past the cap
  function automatic bit release_byte(input logic [7:0] v, output out_beat_t r);
    r = '0;
    if (dlv_count >= PAYLOAD_CAP) begin
      ovf_seen = 1'b1;
      return 1'b0;
    end
    dlv_count++;
    crc_acc = crc_byte(crc_acc, v);
    sum_acc = sum_acc + v;
    r = pay(v);
    return 1'b1;
  endfunction

  function automatic bit take_data(input logic [7:0] v, output out_beat_t r);
    int h;
    logic [7:0] oldest;
    h = trailer_bytes();
    r = '0;
    if (held_fill < h) begin
      held[held_fill[0]] = v;
      held_fill++;
      return 1'b0;
    end
    if (held_fill == 0) return release_byte(v, r);
    oldest = held[0];
    if (held_fill >= 2) begin
      held[0] = held[1];
      held[1] = v;
    end else begin
      held[0] = v;
    end
    return release_byte(oldest, r);
  endfunction

  function automatic bit deframe_step(input in_beat_t b, output out_beat_t r);
    int h;
    frame_status_t st;
    logic [1:0] last;
    r = '0;
    if (b.command == CMD_ABORT) begin
      if (rx_state == PM_FRAME || rx_state == PM_ESCAPED) begin
        rx_state = PM_IDLE;
        r = fin(ST_ABORT, dlv_count);
        return 1'b1;
      end
      rx_state = PM_IDLE;
      return 1'b0;
    end
    case (rx_state)
      PM_IDLE: begin
        if (b.rx_byte == CH_DLE) begin
          rx_state = PM_SKIP;
        end else if (b.rx_byte == CH_STX) begin
          open_frame();
          rx_state = PM_FRAME;
        end
        return 1'b0;
      end
      PM_SKIP: begin
        rx_state = PM_IDLE;
        return 1'b0;
      end
      PM_ESCAPED: begin
        rx_state = PM_FRAME;
        return take_data(b.rx_byte, r);
      end
      default: ;
    endcase
    if (b.rx_byte == CH_DLE) begin
      rx_state = PM_ESCAPED;
      return 1'b0;
    end
    if (b.rx_byte == CH_STX) begin
      r = fin(ST_RESTART, dlv_count);
      open_frame();
      rx_state = PM_FRAME;
      return 1'b1;
    end
    if (b.rx_byte == CH_ETX) begin
      h = trailer_bytes();
      st = ST_GOOD;
      if (ovf_seen) begin
        st = ST_OVERFLOW;
      end else if (h > 0 && (held_fill < h || dlv_count == 0)) begin
        st = ST_SHORT;
      end else if (h == 2) begin
        if ({held[0], held[1]} != crc_acc) st = ST_BADSUM;
      end else if (h == 1) begin
        // the newest held byte is the sum trailer
        last = held_fill - 2'd1;
        if (held[last[0]] != 8'(8'd0 - sum_acc)) st = ST_BADSUM;
      end
      rx_state = PM_IDLE;
      r = fin(st, dlv_count);
      return 1'b1;
    end
    return take_data(b.rx_byte, r);
  endfunction

  // called at a falling edge; returns at a falling edge with valid still up, or low after a random gap
  task automatic send_beat(input in_beat_t b, input check_t kind, input out_beat_t want);
    out_beat_t r;
    bit got_any;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    got_any = deframe_step(b, r);
    if (kind == CHK_BEAT) begin
      deframed_due.push_back(want);
    end else if (kind == CHK_PREDICT && got_any) begin
      deframed_due.push_back(r);
    end
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] v);
    in_beat_t b;
    b.command = CMD_BYTE;
    b.rx_byte = v;
    send_beat(b, CHK_PREDICT, '0);
  endtask

  task automatic send_abort();
    in_beat_t b;
    b.command = CMD_ABORT;
    b.rx_byte = 8'($urandom_range(0, 255));
    send_beat(b, CHK_PREDICT, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (deframed_due.size() != 0) @(negedge clk);
    // a beat with no result may still be in flight
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= 32'(m);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mode_reg = m;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== 32'(m)) begin
      note_mismatch($sformatf("checksum_mode read %0h, wrote %0h", prdata, m));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] line_byte();
    case ($urandom_range(0, 11))
      0: return CH_STX;
      1: return CH_ETX;
      2: return CH_DLE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one stuffed frame; clean frames carry a correct trailer and close with etx
  task automatic send_frame(input int n_pay, input bit clean);
    logic [7:0] body[$];
    logic [7:0] v;
    logic [15:0] c;
    logic [7:0] s;
    int h;
    int pick;
    h = trailer_bytes();
    c = CRC_INIT;
    s = '0;
    if (!clean && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) send_abort();
        else send_byte(line_byte());
      end
    end
    for (int i = 0; i < n_pay; i++) begin
      v = line_byte();
      body.push_back(v);
      c = crc_byte(c, v);
      s = s + v;
    end
    if (h == 2) begin
      body.push_back(c[15:8]);
      body.push_back(c[7:0]);
    end else if (h == 1) begin
      body.push_back(8'(8'd0 - s));
    end
    if (!clean && body.size() > 0 && $urandom_range(0, 7) == 0) begin
      pick = $urandom_range(0, body.size() - 1);
      body[pick][$urandom_range(0, 7)] ^= 1'b1;
    end
    send_byte(CH_STX);
    foreach (body[i]) begin
      if ((body[i] == CH_STX || body[i] == CH_ETX || body[i] == CH_DLE) &&
          (clean || $urandom_range(0, 31) != 0)) begin
        send_byte(CH_DLE);
      end
      send_byte(body[i]);
    end
    pick = clean ? 0 : $urandom_range(0, 15);
    if (pick < 12) send_byte(CH_ETX);
    else if (pick == 12) send_abort();
    else if (pick == 13) send_byte(CH_STX);
  endtask

  // receiver: short random stalls, one long hold-off on request
  initial begin : sink
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!calm_tail && !rst && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (deframed_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat %h", out_data));
      end else begin
        want = deframed_due.pop_front();
        if (out_data.is_frame_end !== want.is_frame_end)
          note_mismatch($sformatf("is_frame_end %0d, want %0d",
                                  out_data.is_frame_end, want.is_frame_end));
        if (out_data.payload_byte !== want.payload_byte)
          note_mismatch($sformatf("payload_byte %h, want %h",
                                  out_data.payload_byte, want.payload_byte));
        if (out_data.frame_status !== want.frame_status)
          note_mismatch($sformatf("frame_status %0d, want %0d",
                                  out_data.frame_status, want.frame_status));
        if (out_data.payload_length !== want.payload_length)
          note_mismatch($sformatf("payload_length %0d, want %0d",
                                  out_data.payload_length, want.payload_length));
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("stuffed_frame_receiver_core: mismatch");
    $finish;
  end

  initial begin : stimulus
    int stop;
    logic [1:0] m;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_count = 0;
    beats_sent = 0;
    calm_tail = 1'b0;
    hold_req = 1'b0;
    mode_reg = CSUM_NONE;
    rx_state = PM_IDLE;
    open_frame();

    // mode none after reset
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h55, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_DLE, CHK_NONE, '0));
    // abort while idle cancels the pending skip, so the stx opens a frame
    dir_rows.push_back(mk_row(-1, CMD_ABORT, 8'h00, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h00, CHK_BEAT, pay(8'h00)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'hFF, CHK_BEAT, pay(8'hFF)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_DLE, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_BEAT, pay(CH_STX)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_BEAT, fin(ST_RESTART, 3)));
    dir_rows.push_back(mk_row(-1, CMD_ABORT, 8'hFF, CHK_BEAT, fin(ST_ABORT, 0)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_BEAT, fin(ST_GOOD, 0)));
    // sum trailer
    dir_rows.push_back(mk_row(CSUM_SUM8, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h01, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'hFF, CHK_BEAT, pay(8'h01)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_BEAT, fin(ST_GOOD, 1)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h05, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_BEAT, fin(ST_SHORT, 0)));
    // crc trailer, then a switch to the unused mode with two bytes held
    dir_rows.push_back(mk_row(CSUM_CRC16, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h41, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_BEAT, fin(ST_SHORT, 0)));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_STX, CHK_NONE, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h31, CHK_PREDICT, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h12, CHK_PREDICT, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, 8'h34, CHK_PREDICT, '0));
    dir_rows.push_back(mk_row(3, CMD_BYTE, 8'h56, CHK_PREDICT, '0));
    dir_rows.push_back(mk_row(-1, CMD_BYTE, CH_ETX, CHK_BEAT, fin(ST_GOOD, 2)));

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_mode >= 0) set_mode(2'(dir_rows[i].new_mode));
      send_beat(dir_rows[i].beat, dir_rows[i].kind, dir_rows[i].want);
    end

    // modes cycle 0, 3, 2, 1, ...; frames may be left open across a mode write
    for (int p = 0; p < 8; p++) begin
      m = 2'((p * 3) % 4);
      set_mode(m);
      calm_tail = (p == 7);
      if (p == 1) hold_req = 1'b1;
      if (p == 3) begin
        // overflow with a crc trailer, then let everything drain
        send_frame(PAYLOAD_CAP + 6, 1'b1);
        wait_drained();
      end
      if (p == 4) send_frame(PAYLOAD_CAP, 1'b1);
      stop = beats_sent + 15;
      while (beats_sent < stop) begin
        send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12), 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (deframed_due.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("stuffed_frame_receiver_core: match");
    end else begin
      $display("stuffed_frame_receiver_core: mismatch");
    end
    $finish;
  end

endmodule
